// ===== src/sjf_nonpreemptive_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_macros.svh
// assertion macros used by the scheduler datapath
// ----------------------------------------------------------------------------
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_MACROS_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define SJF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication
`define SJF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== src/sjf_pkg.sv =====
// ----------------------------------------------------------------------------
// sjf_pkg
// widths, controller states and control structs of the sjf scheduler
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int TAG_W    = 8;
  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int TIME_W   = 24;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic scan_init;
    logic scan;
    logic take;
    logic jump;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic scan_last;
    logic best_found;
    logic out_free;
    logic batch_done;
  } status_t;

endpackage

// ===== src/sjf_if.sv =====
// ----------------------------------------------------------------------------
// sjf_if
// request channels of the sjf scheduler: job records in, results out
// ----------------------------------------------------------------------------
interface sjf_in_if;
  import sjf_pkg::*;

  logic               valid;
  logic               ready;
  logic [TAG_W-1:0]   job_tag;
  logic [ARR_W-1:0]   arrival_time;
  logic [BURST_W-1:0] burst_time;
  logic               last_job;

  modport source (output valid, job_tag, arrival_time, burst_time, last_job, input ready);
  modport sink (input valid, job_tag, arrival_time, burst_time, last_job, output ready);
endinterface

interface sjf_out_if;
  import sjf_pkg::*;

  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  done_tag;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [TIME_W-1:0] waiting_time;
  logic              last_result;

  modport source (output valid, done_tag, completion_time, turnaround_time, waiting_time,
                  last_result, input ready);
  modport sink (input valid, done_tag, completion_time, turnaround_time, waiting_time,
                last_result, output ready);
endinterface

// ===== src/sjf_datapath.sv =====
// ----------------------------------------------------------------------------
// sjf_datapath
// job store, scan registers, tick arithmetic and output register
// ----------------------------------------------------------------------------
`include "sjf_nonpreemptive_scheduler_macros.svh"

module sjf_datapath (
  input  logic            clk,
  input  logic            rst,
  input  sjf_pkg::cmd_t   cmd,
  output sjf_pkg::status_t status,
  sjf_in_if.sink          job_in,
  sjf_out_if.source       result_out
);
  import sjf_pkg::*;

  logic [TAG_W-1:0]   tag_store     [MAX_JOBS];
  logic [ARR_W-1:0]   arrival_store [MAX_JOBS];
  logic [BURST_W-1:0] burst_store   [MAX_JOBS];
  logic [MAX_JOBS-1:0] finished;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   done_cnt;
  logic [TIME_W-1:0]  tick;
  logic [IDX_W-1:0]   idx;

  logic               best_found;
  logic [IDX_W-1:0]   best_idx;
  logic [TAG_W-1:0]   best_tag;
  logic [ARR_W-1:0]   best_arr;
  logic [BURST_W-1:0] best_burst;
  logic [ARR_W-1:0]   earliest;
  logic [ARR_W:0]     arr_burst;

  logic               out_valid;
  logic [TAG_W-1:0]   out_tag;
  logic [TIME_W-1:0]  out_ct;
  logic [TIME_W-1:0]  out_tat;
  logic [TIME_W-1:0]  out_wt;
  logic               out_last;

  logic               fire;
  logic               full;
  logic [TAG_W-1:0]   rd_tag;
  logic [ARR_W-1:0]   rd_arr;
  logic [BURST_W-1:0] rd_burst;
  logic               rd_ready;
  logic               rd_better;
  logic [CNT_W-1:0]   done_inc;

  assign job_in.ready = cmd.accept;
  assign fire         = job_in.valid & cmd.accept;
  assign full         = (count == CNT_W'(MAX_JOBS));

  assign rd_tag   = tag_store[idx];
  assign rd_arr   = arrival_store[idx];
  assign rd_burst = burst_store[idx];
  assign rd_ready = !finished[idx] && ({(TIME_W-ARR_W)'(0), rd_arr} <= tick);
  assign rd_better = !best_found || (rd_burst < best_burst) ||
                     ((rd_burst == best_burst) && (rd_arr < best_arr));
  assign done_inc = done_cnt + CNT_W'(1);

  assign status.in_fire    = fire;
  assign status.in_last    = job_in.last_job;
  assign status.scan_last  = ({1'b0, idx} == CNT_W'(count - CNT_W'(1)));
  assign status.best_found = best_found;
  assign status.out_free   = !out_valid || result_out.ready;
  assign status.batch_done = (done_inc == count);

  // job store
  always_ff @(posedge clk) begin
    if (fire && !full) begin
      tag_store[count[IDX_W-1:0]]     <= job_in.job_tag;
      arrival_store[count[IDX_W-1:0]] <= job_in.arrival_time;
      burst_store[count[IDX_W-1:0]]   <= job_in.burst_time;
    end
  end

  // batch control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      finished <= '0;
      done_cnt <= '0;
    end else begin
      if (cmd.finish) begin
        count    <= '0;
        finished <= '0;
      end else begin
        if (fire && !full) begin
          count <= count + CNT_W'(1);
        end
        if (cmd.take) begin
          finished[best_idx] <= 1'b1;
        end
      end
      if (cmd.start) begin
        done_cnt <= '0;
      end else if (cmd.emit) begin
        done_cnt <= done_inc;
      end
    end
  end

  // scan over stored jobs
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      idx        <= '0;
    end else if (cmd.scan_init) begin
      best_found <= 1'b0;
      idx        <= '0;
      earliest   <= '1;
    end else if (cmd.scan) begin
      idx <= idx + IDX_W'(1);
      if (!finished[idx] && rd_arr < earliest) begin
        earliest <= rd_arr;
      end
      if (rd_ready && rd_better) begin
        best_found <= 1'b1;
        best_idx   <= idx;
        best_tag   <= rd_tag;
        best_arr   <= rd_arr;
        best_burst <= rd_burst;
      end
    end
  end

  // current tick
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tick <= '0;
    end else if (cmd.jump) begin
      tick <= {(TIME_W-ARR_W)'(0), earliest};
    end else if (cmd.take) begin
      tick      <= tick + {(TIME_W-BURST_W)'(0), best_burst};
      arr_burst <= {1'b0, best_arr} + {1'b0, best_burst};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tag  <= best_tag;
      out_ct   <= tick;
      out_tat  <= tick - {(TIME_W-ARR_W)'(0), best_arr};
      out_wt   <= tick - {(TIME_W-ARR_W-1)'(0), arr_burst};
      out_last <= status.batch_done;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.done_tag        = out_tag;
  assign result_out.completion_time = out_ct;
  assign result_out.turnaround_time = out_tat;
  assign result_out.waiting_time    = out_wt;
  assign result_out.last_result     = out_last;

  `SJF_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_JOBS))
  `SJF_ASSERT_NOW(a_emit_slot_free, cmd.emit, !out_valid || result_out.ready)
  `SJF_ASSERT_NOW(a_best_arrived, cmd.scan && best_found,
                  {(TIME_W-ARR_W)'(0), best_arr} <= tick && !finished[best_idx])
  `SJF_ASSERT_NEXT(a_take_marks, cmd.take, finished[$past(best_idx)])
  `SJF_ASSERT_NOW(a_done_bound, !cmd.accept, done_cnt < count)

endmodule

// ===== src/sjf_controller.sv =====
// ----------------------------------------------------------------------------
// sjf_controller
// sequencer for loading, scanning, deciding and emitting results
// ----------------------------------------------------------------------------
module sjf_controller (
  input  logic             clk,
  input  logic             rst,
  input  sjf_pkg::status_t status,
  output sjf_pkg::cmd_t    cmd
);
  import sjf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        cmd.accept = 1'b1;
        if (status.in_fire && status.in_last) begin
          cmd.start     = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.best_found) begin
          cmd.take   = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.jump      = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.batch_done) begin
            cmd.finish = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== src/sjf_nonpreemptive_scheduler.sv =====
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler
// non-preemptive shortest-job-first scheduler over a batch of up to 16 jobs
// ----------------------------------------------------------------------------
// Job records are taken one per cycle while the block is loading; a record
// beyond 16 stored jobs is dropped, and the record with last_job set closes
// the batch. Each scheduling decision scans the stored jobs one entry per
// cycle; when no waiting job has arrived yet, the clock jumps to the next
// arrival and the jobs are scanned once more. Results leave through an
// output register, and no new records are taken until the last result of
// the batch has been loaded into it.
module sjf_nonpreemptive_scheduler (
  input  logic      clk,
  input  logic      rst,
  sjf_in_if.sink    job_in,
  sjf_out_if.source result_out
);
  import sjf_pkg::*;

  cmd_t    cmd;
  status_t status;

  sjf_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  sjf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .job_in     (job_in),
    .result_out (result_out)
  );

endmodule
